FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LCFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define LCFD_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: sv/lcfd_pkg.sv
// ----------------------------------------------------------------------------
// LED command frame decoder package
// Constants, command codes and the control and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lcfd_pkg;

	localparam int LED_COUNT     = 8;
	localparam int FRAME_DEPTH   = 32;
	localparam int PATTERN_BYTES = LED_COUNT * 3;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 5;
	localparam int SHIFT_W = 4;

	localparam int FRAME_AW = $clog2(FRAME_DEPTH);
	localparam int PAT_AW   = $clog2(PATTERN_BYTES);
	localparam int LED_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	localparam logic [BYTE_W-1:0] SYNC_CHAR   = 8'h21;
	localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd24;
	localparam logic [BYTE_W-1:0] CMD_CLEAR   = 8'h10;
	localparam logic [BYTE_W-1:0] CMD_ALL     = 8'h11;
	localparam logic [BYTE_W-1:0] CMD_ONE     = 8'h15;
	localparam logic [BYTE_W-1:0] CMD_LIST    = 8'h1D;
	localparam logic [BYTE_W-1:0] END_CR      = 8'h0D;
	localparam logic [BYTE_W-1:0] END_LF      = 8'h0A;
	localparam logic [3:0]        TYPE_NIBBLE = 4'h1;

	localparam int POS_SYNC     = 1;
	localparam int POS_LEN      = 3;
	localparam int END_OFFSET   = 5;
	localparam int OPER_BASE    = 4;
	localparam int OPER_ONE     = 5;

	localparam logic [SHIFT_W-1:0] BRIGHT_RESET = 4'd2;

	typedef struct packed {
		logic accept;
		logic step;
		logic emit;
	} lcfd_ctl_t;

	typedef struct packed {
		logic cmd_start;
		logic last_byte;
		logic out_free;
	} lcfd_sts_t;

endpackage

FILE: sv/lcfd_ctrl.sv
// ----------------------------------------------------------------------------
// LED command frame decoder controller
// Sequences byte intake, the pattern update pass and the pattern output pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcfd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  lcfd_pkg::lcfd_sts_t sts,
	output lcfd_pkg::lcfd_ctl_t ctl
);
	import lcfd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		rx_stall   = (state_q != ST_IDLE);
		ctl.accept = rx_valid && (state_q == ST_IDLE);
		ctl.step   = (state_q == ST_EXEC);
		ctl.emit   = (state_q == ST_EMIT) && sts.out_free;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.accept && sts.cmd_start) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.last_byte) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.last_byte && sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`LCFD_ASSERT(a_start_exec, (ctl.accept && sts.cmd_start) |=> (state_q == ST_EXEC), "command start did not enter update pass")
	`LCFD_ASSERT(a_emit_done, (state_q == ST_IDLE && $past(state_q) == ST_EMIT) |-> $past(sts.last_byte && sts.out_free), "output pass left before last transfer")

endmodule

FILE: sv/lcfd_datapath.sv
// ----------------------------------------------------------------------------
// LED command frame decoder datapath
// Frame store and checks, held LED pattern, update sequencer, brightness
// register and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcfd_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lcfd_pkg::lcfd_ctl_t             ctl,
	output lcfd_pkg::lcfd_sts_t             sts,
	input  logic [lcfd_pkg::BYTE_W-1:0]     rx_byte,
	input  logic                            cfg_valid,
	input  logic [lcfd_pkg::SHIFT_W-1:0]    brightness_shift,
	output logic                            led_valid,
	input  logic                            led_stall,
	output logic [lcfd_pkg::BYTE_W-1:0]     led_byte,
	output logic [lcfd_pkg::POS_W-1:0]      byte_position,
	output logic                            is_last
);
	import lcfd_pkg::*;

	logic [BYTE_W-1:0]   frame_q [FRAME_DEPTH];
	logic [FRAME_AW-1:0] idx_q;
	logic [FRAME_AW-1:0] idx_nxt;
	logic                in_sync_q;
	logic                sync_nxt;
	logic [BYTE_W-1:0]   pat_q [PATTERN_BYTES];
	logic [PAT_AW-1:0]   j_q;
	logic [LED_W-1:0]    led_q;
	logic [1:0]          col_q;
	logic [SHIFT_W-1:0]  bright_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic [POS_W-1:0]    out_pos_q;
	logic                out_last_q;

	logic                sync_ok;
	logic                hdr_bad;
	logic                at_end;
	logic                end_ok;
	logic                known_cmd;
	logic                restart;
	logic                start;
	logic [FRAME_AW-1:0] col_off;
	logic [FRAME_AW-1:0] src_addr;
	logic [BYTE_W-1:0]   src_byte;
	logic                list_fill;
	logic                one_hit;
	logic                wr_en;
	logic [BYTE_W-1:0]   wr_byte;
	logic                j_last;

	// frame checks on the byte being taken
	always_comb begin
		sync_ok   = (frame_q[0] == SYNC_CHAR) && (rx_byte == SYNC_CHAR);
		hdr_bad   = (frame_q[2][7:4] != TYPE_NIBBLE) || (rx_byte > MAX_PAYLOAD);
		at_end    = ({1'b0, frame_q[3]} + 9'(END_OFFSET)) == 9'(idx_q);
		end_ok    = (rx_byte == END_CR) || (rx_byte == END_LF);
		known_cmd = frame_q[2] inside {CMD_CLEAR, CMD_ALL, CMD_ONE, CMD_LIST};
		restart   = 1'b0;
		start     = 1'b0;
		sync_nxt  = in_sync_q;
		if (idx_q == FRAME_AW'(POS_SYNC)) begin
			sync_nxt = sync_ok;
			restart  = !sync_ok;
		end else if (in_sync_q && idx_q == FRAME_AW'(POS_LEN)) begin
			if (hdr_bad) begin
				sync_nxt = 1'b0;
				restart  = 1'b1;
			end
		end else if (in_sync_q && idx_q > FRAME_AW'(POS_LEN) && at_end) begin
			sync_nxt = 1'b0;
			restart  = 1'b1;
			start    = end_ok && known_cmd;
		end
		if (restart || idx_q == FRAME_AW'(FRAME_DEPTH - 1)) begin
			idx_nxt = '0;
		end else begin
			idx_nxt = idx_q + FRAME_AW'(1);
		end
	end

	// pattern update: one byte per step, RGB operand order swapped to GRB
	always_comb begin
		case (col_q)
			2'd0:    col_off = FRAME_AW'(1);
			2'd1:    col_off = FRAME_AW'(0);
			default: col_off = FRAME_AW'(2);
		endcase
		case (frame_q[2])
			CMD_ONE:  src_addr = FRAME_AW'(OPER_ONE) + col_off;
			CMD_LIST: src_addr = FRAME_AW'(OPER_BASE) + FRAME_AW'(led_q) * FRAME_AW'(3) + col_off;
			default:  src_addr = FRAME_AW'(OPER_BASE) + col_off;
		endcase
		src_byte  = frame_q[src_addr];
		list_fill = (8'(led_q) * 8'd3 + 8'd3) <= frame_q[3];
		one_hit   = (frame_q[4] < 8'(LED_COUNT)) && (frame_q[4][LED_W-1:0] == led_q);
		case (frame_q[2])
			CMD_CLEAR: begin
				wr_en   = 1'b1;
				wr_byte = '0;
			end
			CMD_ALL: begin
				wr_en   = 1'b1;
				wr_byte = src_byte;
			end
			CMD_ONE: begin
				wr_en   = one_hit;
				wr_byte = src_byte;
			end
			CMD_LIST: begin
				wr_en   = 1'b1;
				wr_byte = list_fill ? src_byte : '0;
			end
			default: begin
				wr_en   = 1'b0;
				wr_byte = '0;
			end
		endcase
	end

	assign j_last        = (j_q == PAT_AW'(PATTERN_BYTES - 1));
	assign sts.cmd_start = start;
	assign sts.last_byte = j_last;
	assign sts.out_free  = !out_valid_q || !led_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_DEPTH; i++) begin
				frame_q[i] <= '0;
			end
			idx_q     <= '0;
			in_sync_q <= 1'b0;
		end else if (ctl.accept) begin
			frame_q[idx_q] <= rx_byte;
			idx_q          <= idx_nxt;
			in_sync_q      <= sync_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_BYTES; i++) begin
				pat_q[i] <= '0;
			end
		end else if (ctl.step && wr_en) begin
			pat_q[j_q] <= wr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q   <= '0;
			led_q <= '0;
			col_q <= '0;
		end else if (ctl.accept && start) begin
			j_q   <= '0;
			led_q <= '0;
			col_q <= '0;
		end else if (ctl.step || ctl.emit) begin
			j_q <= j_last ? '0 : j_q + PAT_AW'(1);
			if (col_q == 2'd2) begin
				col_q <= '0;
				led_q <= (led_q == LED_W'(LED_COUNT - 1)) ? '0 : led_q + LED_W'(1);
			end else begin
				col_q <= col_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_RESET;
		end else if (cfg_valid) begin
			bright_q <= brightness_shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!led_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_byte_q <= pat_q[j_q] >> bright_q;
			out_pos_q  <= POS_W'(j_q);
			out_last_q <= j_last;
		end
	end

	assign led_valid     = out_valid_q;
	assign led_byte      = out_byte_q;
	assign byte_position = out_pos_q;
	assign is_last       = out_last_q;

	`LCFD_ASSERT(a_emit_free, ctl.emit |-> (!out_valid_q || !led_stall), "output register overwritten while stalled")
	`LCFD_NEVER(a_step_emit, ctl.step && (ctl.emit || ctl.accept), "update pass overlaps intake or output")
	`LCFD_ASSERT(a_sync_pos, in_sync_q |-> (idx_q >= FRAME_AW'(2)), "sync flag set before sync pair position")

endmodule

FILE: sv/led_command_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// LED command frame decoder core
// Deframes '!!' command frames from a byte stream, updates the held 8-LED
// pattern and sends out its 24 GRB bytes scaled by the brightness shift.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  rx        in         rx_valid / rx_stall    rx_byte
//  led       out        led_valid / led_stall  led_byte, byte_position, is_last
//  cfg       in         cfg_valid / cfg_ready  brightness_shift
//
//  A byte that does not complete a command is taken without stalling rx.
//  A byte that completes a command stalls rx for a pattern update (one
//  pattern byte per cycle, written where the command changes it) and then
//  for 24 led transfers, one per cycle when led_stall is low.
//  Reset clears frame store and pattern to zero and brightness shift to 2.
// ----------------------------------------------------------------------------
module led_command_frame_decoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rx_valid,
	output logic                            rx_stall,
	input  logic [lcfd_pkg::BYTE_W-1:0]     rx_byte,
	output logic                            led_valid,
	input  logic                            led_stall,
	output logic [lcfd_pkg::BYTE_W-1:0]     led_byte,
	output logic [lcfd_pkg::POS_W-1:0]      byte_position,
	output logic                            is_last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lcfd_pkg::SHIFT_W-1:0]    brightness_shift
);
	import lcfd_pkg::*;

	lcfd_ctl_t ctl;
	lcfd_sts_t sts;

	assign cfg_ready = 1'b1;

	lcfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	lcfd_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.rx_byte          (rx_byte),
		.cfg_valid        (cfg_valid),
		.brightness_shift (brightness_shift),
		.led_valid        (led_valid),
		.led_stall        (led_stall),
		.led_byte         (led_byte),
		.byte_position    (byte_position),
		.is_last          (is_last)
	);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED command frame decoder testbench
// Feeds directed and random byte streams of '!!' command frames (well-formed,
// broken and noise) into the core, tracks frame state and the held LED
// pattern in a local decoder, and checks every emitted pattern byte in order.
// Brightness shift is rewritten between phases; both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import lcfd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 60;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic [POS_W-1:0]  pos;
		logic              last;
	} led_out_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               rx_valid = 1'b0;
	logic               rx_stall;
	logic [BYTE_W-1:0]  rx_byte = '0;
	logic               led_valid;
	logic               led_stall = 1'b0;
	logic [BYTE_W-1:0]  led_byte;
	logic [POS_W-1:0]   byte_position;
	logic               is_last;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [SHIFT_W-1:0] brightness_shift = BRIGHT_RESET;

	logic [BYTE_W-1:0] rx_byte_q[$];
	led_out_t          led_expect_q[$];
	led_out_t          led_want;

	logic [BYTE_W-1:0]  frame_mem[0:FRAME_DEPTH-1];
	logic [BYTE_W-1:0]  pattern[0:PATTERN_BYTES-1];
	int                 frame_pos;
	bit                 synced;
	logic [SHIFT_W-1:0] bright_now;

	int  bytes_queued;
	int  bytes_taken;
	int  led_checked;
	int  commands_run;
	int  cfg_writes;
	int  fail_count;
	int  hold_req;
	int  hold_seen;
	int  hold_left;
	int  stall_left;
	int  tx_gap;
	int  quiet_cycles;
	bit  tx_gaps_on;
	bit  rx_stalls_on;

	led_command_frame_decoder_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.rx_valid         (rx_valid),
		.rx_stall         (rx_stall),
		.rx_byte          (rx_byte),
		.led_valid        (led_valid),
		.led_stall        (led_stall),
		.led_byte         (led_byte),
		.byte_position    (byte_position),
		.is_last          (is_last),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.brightness_shift (brightness_shift)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(0, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void put_led(input int led, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		if (led >= LED_COUNT)
			return;
		pattern[led * 3 + 0] = g;
		pattern[led * 3 + 1] = r;
		pattern[led * 3 + 2] = b;
	endfunction

	function automatic void emit_pattern();
		led_out_t e;
		for (int i = 0; i < PATTERN_BYTES; i++) begin
			e.value = pattern[i] >> bright_now;
			e.pos   = i[POS_W-1:0];
			e.last  = (i == PATTERN_BYTES - 1);
			led_expect_q.push_back(e);
		end
		commands_run++;
	endfunction

	function automatic void run_command();
		int len;
		len = int'(frame_mem[POS_LEN]);
		case (frame_mem[2])
			CMD_CLEAR: begin
				for (int i = 0; i < PATTERN_BYTES; i++)
					pattern[i] = '0;
				emit_pattern();
			end
			CMD_ALL: begin
				for (int i = 0; i < LED_COUNT; i++)
					put_led(i, frame_mem[4], frame_mem[5], frame_mem[6]);
				emit_pattern();
			end
			CMD_ONE: begin
				put_led(int'(frame_mem[4]), frame_mem[5], frame_mem[6], frame_mem[7]);
				emit_pattern();
			end
			CMD_LIST: begin
				for (int i = 0; i < PATTERN_BYTES; i++)
					pattern[i] = '0;
				for (int i = 0; i < len / 3 && i < LED_COUNT; i++)
					put_led(i, frame_mem[4 + 3 * i], frame_mem[5 + 3 * i], frame_mem[6 + 3 * i]);
				emit_pattern();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		int pos;
		bit restart;
		pos = frame_pos;
		restart = 1'b0;
		frame_mem[pos] = b;
		if (pos == POS_SYNC) begin
			if (frame_mem[0] == SYNC_CHAR && frame_mem[1] == SYNC_CHAR) begin
				synced = 1'b1;
			end else begin
				synced = 1'b0;
				restart = 1'b1;
			end
		end
		if (!restart && synced && pos == POS_LEN) begin
			if (frame_mem[2][7:4] != TYPE_NIBBLE || frame_mem[POS_LEN] > MAX_PAYLOAD) begin
				synced = 1'b0;
				restart = 1'b1;
			end
		end
		if (!restart && synced && pos > POS_LEN && pos == frame_mem[POS_LEN] + END_OFFSET) begin
			if (b == END_CR || b == END_LF)
				run_command();
			synced = 1'b0;
			restart = 1'b1;
		end
		frame_pos = restart ? 0 : (pos + 1) % FRAME_DEPTH;
	endfunction

	function automatic void push_byte(input logic [BYTE_W-1:0] b);
		rx_byte_q.push_back(b);
		bytes_queued++;
	endfunction

	function automatic int queue_frame();
		int kind;
		int len;
		int sel;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] typ;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			len = $urandom_range(1, 4);
			for (int i = 0; i < len; i++) begin
				b = BYTE_W'($urandom_range(0, 255));
				push_byte(b);
			end
			return len;
		end
		push_byte(SYNC_CHAR);
		if (kind < 10) begin
			b = BYTE_W'($urandom_range(0, 255));
			if (b == SYNC_CHAR)
				b = '0;
			push_byte(b);
			return 2;
		end
		push_byte(SYNC_CHAR);
		if (kind < 14) begin
			typ = BYTE_W'($urandom_range(0, 255));
			if (typ[7:4] == TYPE_NIBBLE)
				typ[7:4] = 4'hF;
			push_byte(typ);
			b = BYTE_W'($urandom_range(0, 255));
			push_byte(b);
			return 4;
		end
		sel = $urandom_range(0, 4);
		case (sel)
			0: begin typ = CMD_CLEAR; len = 0; end
			1: begin typ = CMD_ALL; len = 3; end
			2: begin typ = CMD_ONE; len = 4; end
			3: begin typ = CMD_LIST; len = 3 * $urandom_range(0, 8); end
			default: begin typ = {TYPE_NIBBLE, 4'($urandom_range(0, 15))}; len = $urandom_range(0, 24); end
		endcase
		push_byte(typ);
		if (kind < 18) begin
			b = BYTE_W'($urandom_range(25, 255));
			push_byte(b);
			return 4;
		end
		if ($urandom_range(0, 99) < 15)
			len = $urandom_range(0, 24);
		b = BYTE_W'(len);
		push_byte(b);
		for (int i = 0; i < len; i++) begin
			b = BYTE_W'($urandom_range(0, 255));
			if (i == 0 && typ == CMD_ONE)
				b = ($urandom_range(0, 99) < 80) ? BYTE_W'($urandom_range(0, LED_COUNT - 1)) :
					BYTE_W'($urandom_range(LED_COUNT, 255));
			push_byte(b);
		end
		b = BYTE_W'($urandom_range(0, 255));
		push_byte(b);
		if ($urandom_range(0, 99) < 90)
			b = $urandom_range(0, 1) ? END_CR : END_LF;
		else
			b = BYTE_W'($urandom_range(0, 255));
		push_byte(b);
		return len + 6;
	endfunction

	task automatic queue_random(input int n);
		int added;
		added = 0;
		while (added < n)
			added += queue_frame();
	endtask

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (bytes_taken != bytes_queued || led_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_brightness(input logic [SHIFT_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		brightness_shift <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		bright_now = v;
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// driver: hold the byte while stalled, then advance, after a random gap when gaps are on
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte <= '0;
			tx_gap <= 0;
			for (int i = 0; i < FRAME_DEPTH; i++)
				frame_mem[i] = '0;
			for (int i = 0; i < PATTERN_BYTES; i++)
				pattern[i] = '0;
			frame_pos = 0;
			synced = 1'b0;
		end else begin
			if (rx_valid && !rx_stall) begin
				decode_byte(rx_byte);
				bytes_taken++;
			end
			if (!(rx_valid && rx_stall)) begin
				if (tx_gap > 0) begin
					rx_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (rx_byte_q.size() != 0) begin
					rx_valid <= 1'b1;
					rx_byte <= rx_byte_q.pop_front();
					tx_gap <= tx_gaps_on ? pick_gap() : 0;
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each transfer against the oldest expected pattern byte and drive led_stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			if (led_valid && !led_stall) begin
				led_checked++;
				if (led_expect_q.size() == 0) begin
					$error("unexpected led transfer: led_byte %0h byte_position %0d", led_byte,
						byte_position);
					fail_count++;
				end else begin
					led_want = led_expect_q.pop_front();
					if (led_byte !== led_want.value) begin
						$error("led_byte: expected %0h, actual %0h", led_want.value, led_byte);
						fail_count++;
					end
					if (byte_position !== led_want.pos) begin
						$error("byte_position: expected %0d, actual %0d", led_want.pos, byte_position);
						fail_count++;
					end
					if (is_last !== led_want.last) begin
						$error("is_last: expected %0b, actual %0b", led_want.last, is_last);
						fail_count++;
					end
				end
			end
			if (hold_left > 0) begin
				led_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
				led_stall <= 1'b1;
			end else if (stall_left > 0) begin
				led_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
				led_stall <= 1'b1;
				stall_left <= pick_gap();
			end else begin
				led_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && !rx_stall) || (led_valid && !led_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		bright_now = BRIGHT_RESET;
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// short payload on set-all, out-of-range single LED, broken frames
		push_byte(SYNC_CHAR); push_byte(SYNC_CHAR); push_byte(CMD_ALL); push_byte(8'h00);
		push_byte(8'h00); push_byte(END_CR);
		push_byte(SYNC_CHAR); push_byte(SYNC_CHAR); push_byte(CMD_ONE); push_byte(8'h04);
		push_byte(8'h09); push_byte(8'hFF); push_byte(8'h80); push_byte(8'h01);
		push_byte(8'hFF); push_byte(END_LF);
		push_byte(SYNC_CHAR); push_byte(8'h00);
		push_byte(SYNC_CHAR); push_byte(SYNC_CHAR); push_byte(8'h25); push_byte(8'h00);
		push_byte(SYNC_CHAR); push_byte(SYNC_CHAR); push_byte(CMD_LIST); push_byte(8'h19);
		wait_quiet();

		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		write_brightness(4'd0);
		queue_random(120);
		wait_quiet();

		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		write_brightness(4'd8);
		queue_random(60);
		wait_quiet();

		tx_gaps_on = 1'b0;
		write_brightness(4'd3);
		hold_req++;
		queue_random(100);
		wait_quiet();

		tx_gaps_on = 1'b1;
		repeat (2) begin
			write_brightness(SHIFT_W'($urandom_range(0, 8)));
			queue_random(60);
			wait_quiet();
		end

		if (led_expect_q.size() != 0)
			$error("%0d expected led bytes never arrived", led_expect_q.size());
		$display("run: %0d serial bytes in, %0d commands, %0d led bytes checked, %0d shift writes",
			bytes_taken, commands_run, led_checked, cfg_writes);
		if (fail_count == 0 && led_expect_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
